// File: hdl/rsfp_pkg.sv
// rsfp_pkg: constants, status codes and stream widths of the serial frame parser
// no dependencies; imported by the parser top level and its checker

package rsfp_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int PAYLOAD_CAP     = 44;

    localparam logic [7:0] SYNC0      = 8'hA5;
    localparam logic [7:0] SYNC1      = 8'h5A;
    localparam logic [7:0] LEN_HI_MSK = 8'h7F;
    localparam logic [7:0] TRAILER    = 8'h04;
    localparam logic [7:0] TYPE_ACK   = 8'hDB;
    localparam logic [7:0] ACK_CMD    = 8'hA1;
    localparam logic [7:0] DATA_MAX   = 8'h64;
    localparam logic [7:0] DATA_ALT   = 8'h78;
    localparam logic [7:0] DATA_CMD   = 8'hA0;
    localparam logic [7:0] ACK_OK     = 8'h01;

    // frame layout: header of four bytes, body after it
    localparam int HDR_BYTES   = 4;
    localparam int IDX_B0      = HDR_BYTES + 0;
    localparam int IDX_B1      = HDR_BYTES + 1;
    localparam int IDX_B3      = HDR_BYTES + 3;
    localparam int IDX_B10     = HDR_BYTES + 10;
    localparam int IDX_B11     = HDR_BYTES + 11;
    localparam int IDX_B12     = HDR_BYTES + 12;
    localparam int PAYLOAD_OFS = 14;
    localparam int PAYLOAD_IDX = HDR_BYTES + PAYLOAD_OFS;

    localparam logic [3:0] ST_PENDING  = 4'd0;
    localparam logic [3:0] ST_BAD_HDR  = 4'd1;
    localparam logic [3:0] ST_OVERFLOW = 4'd2;
    localparam logic [3:0] ST_BAD_SUM  = 4'd3;
    localparam logic [3:0] ST_ACK_OK   = 4'd4;
    localparam logic [3:0] ST_ACK_FAIL = 4'd5;
    localparam logic [3:0] ST_DATA     = 4'd6;
    localparam logic [3:0] ST_BAD_CMD  = 4'd7;
    localparam logic [3:0] ST_UNKNOWN  = 4'd8;
    localparam logic [3:0] ST_SHORT    = 4'd9;

    localparam int PLEN_W    = 7;
    localparam int CNT16_W   = 16;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 4;

endpackage

// File: hdl/rsfp_ram.sv
// rsfp_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the frame bytes of the parser

module rsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/radio_serial_frame_parser_unit.sv
// radio_serial_frame_parser_unit: A5 5A length-prefixed frame parser with xor checksum
// depends on rsfp_pkg and rsfp_ram
//
// usage:
// s_ channel takes one serial byte per word in s_tdata[7:0]
// m_ channel gives result words; m_tuser carries the status code, m_tlast
// marks the final word caused by one input byte
// every input byte gives one result word, a good data frame gives one word
// per payload byte (at most 44), read back from the frame ram
// a result word is registered in the evaluate step that follows its byte, the first
// payload word of a data frame after the evaluate, read and send steps
// no new byte is taken until the evaluate step of the last one is done, and each
// payload word waits for the registered read of the frame ram
// one more byte is taken while a result word still waits in the output register
// reset: counters cleared, link quality set to all ones, frame restarts empty,
// no byte is taken while reset is held
// when the receiver stalls, the block holds its output word, takes at most one
// further byte and then waits until that word has been taken

module radio_serial_frame_parser_unit
    import rsfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // data_byte, link_quality, payload_length, received_total, acked_total,
    // error_total, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // status
    output logic                 m_tlast
);

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int CW  = $clog2(FRAME_BYTES + 1);
    localparam int RCW = $clog2(PAYLOAD_CAP + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0]         state_reg;
    logic [CW-1:0]      count_reg;
    logic [7:0]         byte_reg;
    logic [7:0]         xor_reg;
    logic [7:0]         h0_reg, h1_reg, h2_reg, h3_reg;
    logic [7:0]         b0_reg, b1_reg, b3_reg, b10_reg, b11_reg, b12_reg;
    logic [7:0]         quality_reg;
    logic [CNT16_W-1:0] rx_cnt_reg, ack_cnt_reg, err_cnt_reg;
    logic [PLEN_W-1:0]  plen_reg;
    logic [RCW-1:0]     rd_cnt_reg;

    logic               m_valid_reg;
    logic [3:0]         out_status_reg;
    logic [7:0]         out_data_reg;
    logic               out_last_reg;
    logic [PLEN_W-1:0]  out_plen_reg;

    logic               s_accept;
    logic               out_free;
    logic               out_load;
    logic [AW-1:0]      wr_idx;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         ram_rdata;

    logic [14:0]        body_len;
    logic [15:0]        need_cnt;
    logic [14:0]        present;
    logic [15:0]        plen_wide;
    logic [3:0]         ev_status;
    logic               ev_restart;
    logic               ev_err;
    logic               ev_ack;
    logic               ev_data;
    logic [PLEN_W-1:0]  ev_plen;
    logic               send_last;

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_EVAL && !(ev_data && ev_plen != '0))
                                   || state_reg == S_SEND);
    assign wr_idx   = count_reg[AW-1:0];
    assign rd_addr  = AW'(PAYLOAD_IDX) + AW'(rd_cnt_reg);

    rsfp_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_frame_ram (
        .aclk (aclk),
        .we   (s_accept),
        .waddr(wr_idx),
        .wdata(s_tdata),
        .re   (state_reg == S_READ),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // frame evaluation after the byte has been stored
    always_comb begin
        body_len   = {h2_reg[6:0] & LEN_HI_MSK[6:0], h3_reg};
        need_cnt   = 16'(HDR_BYTES + 2) + {1'b0, body_len};
        present    = (body_len > 15'(PAYLOAD_OFS)) ? body_len - 15'(PAYLOAD_OFS) : 15'd0;
        plen_wide  = {b11_reg, b12_reg};
        if (plen_wide > {1'b0, present}) begin
            plen_wide = {1'b0, present};
        end
        if (plen_wide > 16'(PAYLOAD_CAP)) begin
            plen_wide = 16'(PAYLOAD_CAP);
        end
        ev_status  = ST_PENDING;
        ev_restart = 1'b1;
        ev_err     = 1'b1;
        ev_ack     = 1'b0;
        ev_data    = 1'b0;
        ev_plen    = '0;
        if (count_reg == CW'(FRAME_BYTES)) begin
            ev_status = ST_OVERFLOW;
        end else if (count_reg < CW'(HDR_BYTES)) begin
            ev_restart = 1'b0;
            ev_err     = 1'b0;
        end else if (h0_reg != SYNC0 || h1_reg != SYNC1) begin
            ev_status = ST_BAD_HDR;
        end else if (16'(count_reg) < need_cnt) begin
            ev_restart = 1'b0;
            ev_err     = 1'b0;
        end else if (xor_reg != TRAILER || byte_reg != TRAILER) begin
            ev_status = ST_BAD_SUM;
        end else if (body_len == 15'd0) begin
            ev_status = ST_SHORT;
        end else if (b0_reg == TYPE_ACK) begin
            if (body_len < 15'd4) begin
                ev_status = ST_SHORT;
            end else if (b1_reg != ACK_CMD || b3_reg != ACK_OK) begin
                ev_status = ST_ACK_FAIL;
            end else begin
                ev_status = ST_ACK_OK;
                ev_err    = 1'b0;
                ev_ack    = 1'b1;
            end
        end else if (!(b0_reg <= DATA_MAX || b0_reg == DATA_ALT)) begin
            ev_status = ST_UNKNOWN;
        end else if (body_len < 15'd2) begin
            ev_status = ST_SHORT;
        end else if (b1_reg != DATA_CMD) begin
            ev_status = ST_BAD_CMD;
        end else if (body_len < 15'd13) begin
            ev_status = ST_SHORT;
        end else begin
            ev_status = ST_DATA;
            ev_err    = 1'b0;
            ev_data   = 1'b1;
            ev_plen   = plen_wide[PLEN_W-1:0];
        end
    end

    assign send_last = (PLEN_W'(rd_cnt_reg) + PLEN_W'(1)) == plen_reg;

    // byte capture: header and the body bytes used for classification, link quality and length
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg <= s_tdata;
            case (wr_idx)
                AW'(0):       h0_reg  <= s_tdata;
                AW'(1):       h1_reg  <= s_tdata;
                AW'(2):       h2_reg  <= s_tdata;
                AW'(3):       h3_reg  <= s_tdata;
                AW'(IDX_B0):  b0_reg  <= s_tdata;
                AW'(IDX_B1):  b1_reg  <= s_tdata;
                AW'(IDX_B3):  b3_reg  <= s_tdata;
                AW'(IDX_B10): b10_reg <= s_tdata;
                AW'(IDX_B11): b11_reg <= s_tdata;
                AW'(IDX_B12): b12_reg <= s_tdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            xor_reg     <= '0;
            quality_reg <= 8'hFF;
            rx_cnt_reg  <= '0;
            ack_cnt_reg <= '0;
            err_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            rd_cnt_reg  <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        count_reg <= count_reg + CW'(1);
                        if (wr_idx >= AW'(HDR_BYTES)) begin
                            xor_reg <= xor_reg ^ s_tdata;
                        end
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        if (ev_restart) begin
                            count_reg <= '0;
                            xor_reg   <= '0;
                        end
                        if (ev_err) begin
                            err_cnt_reg <= err_cnt_reg + 16'd1;
                        end
                        if (ev_ack) begin
                            ack_cnt_reg <= ack_cnt_reg + 16'd1;
                        end
                        if (ev_data) begin
                            rx_cnt_reg  <= rx_cnt_reg + 16'd1;
                            quality_reg <= b10_reg;
                        end
                        if (ev_data && ev_plen != '0) begin
                            plen_reg   <= ev_plen;
                            rd_cnt_reg <= '0;
                            state_reg  <= S_READ;
                        end else begin
                            out_status_reg <= ev_status;
                            out_data_reg   <= '0;
                            out_last_reg   <= 1'b1;
                            out_plen_reg   <= '0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        out_status_reg <= ST_DATA;
                        out_data_reg   <= ram_rdata;
                        out_last_reg   <= send_last;
                        out_plen_reg   <= plen_reg;
                        if (send_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            rd_cnt_reg <= rd_cnt_reg + RCW'(1);
                            state_reg  <= S_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, err_cnt_reg, ack_cnt_reg, rx_cnt_reg, out_plen_reg,
                       quality_reg, out_data_reg};

endmodule

// File: hdl/rsfp_checker.sv
// rsfp_checker: port-level assertions for the serial frame parser
// depends on rsfp_pkg; bound to radio_serial_frame_parser_unit

module rsfp_checker
    import rsfp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output word changed under stall");

    // anything but payload is a single word with zero data
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DATA |-> m_tlast && m_tdata[7:0] == 8'd0
        && m_tdata[22:16] == 7'd0)
        else $error("non-payload word malformed");

    // a payload burst that continues has a nonzero length
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DATA && !m_tlast |-> m_tdata[22:16] != 7'd0)
        else $error("payload burst with zero length");

    // no input taken in the cycle right after a byte
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("byte taken before evaluation");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind radio_serial_frame_parser_unit rsfp_checker u_rsfp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// File: tb/radio_serial_frame_parser_unit_tb.sv
// radio_serial_frame_parser_unit_tb: self-checking bench for the serial frame parser
// feeds framed and broken byte streams, predicts every result word and compares them
// depends on rsfp_pkg and the parser rtl

module radio_serial_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsfp_pkg::*;

    localparam int ITEM_TARGET = 370;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  lqi;
        logic [6:0]  plen;
        logic [15:0] rx_total;
        logic [15:0] ack_total;
        logic [15:0] err_total;
    } parse_word_t;

    typedef enum int {
        FK_ACK_OK, FK_ACK_FAIL, FK_ACK_SHORT, FK_DATA, FK_BAD_CMD, FK_DATA_SHORT,
        FK_UNKNOWN, FK_BAD_SUM, FK_BAD_TRAILER, FK_BAD_HDR, FK_EMPTY, FK_OVERFLOW,
        FK_NOISE
    } frame_kind_t;

    class frame_scoreboard;
        parse_word_t   due_words[$];
        logic [7:0]    frame_mem[FRAME_BYTES_DEF];
        int unsigned   fill;
        logic [7:0]    lqi;
        logic [15:0]   rx_cnt;
        logic [15:0]   ack_cnt;
        logic [15:0]   err_cnt;
        int            errors;

        function new();
            fill    = 0;
            lqi     = 8'hFF;
            rx_cnt  = '0;
            ack_cnt = '0;
            err_cnt = '0;
            errors  = 0;
        endfunction

        function void emit(logic [3:0] st, logic [7:0] d, logic lst, logic [6:0] pl);
            parse_word_t w;
            w.status    = st;
            w.data      = d;
            w.last      = lst;
            w.lqi       = lqi;
            w.plen      = pl;
            w.rx_total  = rx_cnt;
            w.ack_total = ack_cnt;
            w.err_total = err_cnt;
            due_words.push_back(w);
        endfunction

        function void reject(logic [3:0] st);
            err_cnt = err_cnt + 16'd1;
            fill    = 0;
            emit(st, 8'h00, 1'b1, 7'd0);
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned blen;
            int unsigned present;
            int unsigned plen;
            logic [7:0]  sum;
            if (fill >= FRAME_BYTES_DEF) fill = 0;
            frame_mem[fill] = b;
            fill++;
            if (fill >= FRAME_BYTES_DEF) begin
                reject(ST_OVERFLOW);
                return;
            end
            if (fill < HDR_BYTES) begin
                emit(ST_PENDING, 8'h00, 1'b1, 7'd0);
                return;
            end
            if (frame_mem[0] != SYNC0 || frame_mem[1] != SYNC1) begin
                reject(ST_BAD_HDR);
                return;
            end
            blen = 32'({frame_mem[2] & LEN_HI_MSK, frame_mem[3]});
            if (fill < blen + 6) begin
                emit(ST_PENDING, 8'h00, 1'b1, 7'd0);
                return;
            end
            sum = 8'h00;
            for (int i = 0; i < blen; i++) sum ^= frame_mem[HDR_BYTES + i];
            if (sum != frame_mem[HDR_BYTES + blen] || frame_mem[HDR_BYTES + blen + 1] != TRAILER)
            begin
                reject(ST_BAD_SUM);
                return;
            end
            if (blen == 0) begin
                reject(ST_SHORT);
                return;
            end
            if (frame_mem[IDX_B0] == TYPE_ACK) begin
                if (blen < 4) reject(ST_SHORT);
                else if (frame_mem[IDX_B1] != ACK_CMD || frame_mem[IDX_B3] != ACK_OK)
                    reject(ST_ACK_FAIL);
                else begin
                    ack_cnt = ack_cnt + 16'd1;
                    fill    = 0;
                    emit(ST_ACK_OK, 8'h00, 1'b1, 7'd0);
                end
                return;
            end
            if (!(frame_mem[IDX_B0] <= DATA_MAX || frame_mem[IDX_B0] == DATA_ALT)) begin
                reject(ST_UNKNOWN);
                return;
            end
            if (blen < 2) begin
                reject(ST_SHORT);
                return;
            end
            if (frame_mem[IDX_B1] != DATA_CMD) begin
                reject(ST_BAD_CMD);
                return;
            end
            if (blen < 13) begin
                reject(ST_SHORT);
                return;
            end
            lqi     = frame_mem[IDX_B10];
            plen    = 32'({frame_mem[IDX_B11], frame_mem[IDX_B12]});
            present = (blen > PAYLOAD_OFS) ? blen - PAYLOAD_OFS : 0;
            if (plen > present) plen = present;
            if (plen > PAYLOAD_CAP) plen = PAYLOAD_CAP;
            rx_cnt = rx_cnt + 16'd1;
            fill   = 0;
            if (plen == 0) begin
                emit(ST_DATA, 8'h00, 1'b1, 7'd0);
                return;
            end
            for (int i = 0; i < plen; i++)
                emit(ST_DATA, frame_mem[PAYLOAD_IDX + i], (i + 1 == plen), 7'(plen));
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(parse_word_t got);
            parse_word_t want;
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word status %0h data %0h", $time, got.status,
                         got.data);
                errors++;
                return;
            end
            want = due_words.pop_front();
            compare("status", 16'(want.status), 16'(got.status));
            compare("data_byte", 16'(want.data), 16'(got.data));
            compare("last", 16'(want.last), 16'(got.last));
            compare("link_quality", 16'(want.lqi), 16'(got.lqi));
            compare("payload_length", 16'(want.plen), 16'(got.plen));
            compare("received_total", want.rx_total, got.rx_total);
            compare("acked_total", want.ack_total, got.ack_total);
            compare("error_total", want.err_total, got.err_total);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    frame_scoreboard sb = new();
    int  sent_bytes = 0;
    int  hold_req   = 0;
    bit  quiet      = 1'b0;

    radio_serial_frame_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #8ms;
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: checks words, stalls in short bursts or on a long hold request
    initial begin
        int          stall_left;
        parse_word_t got;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.data      = m_tdata[7:0];
                got.last      = m_tlast;
                got.lqi       = m_tdata[15:8];
                got.plen      = m_tdata[22:16];
                got.rx_total  = m_tdata[38:23];
                got.ack_total = m_tdata[54:39];
                got.err_total = m_tdata[70:55];
                sb.check_word(got);
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
        sent_bytes++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.due_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] data_tag();
        if ($urandom_range(0, 3) == 0) return DATA_ALT;
        return 8'($urandom_range(0, int'(DATA_MAX)));
    endfunction

    function automatic logic [7:0] unknown_tag();
        logic [7:0] t;
        do t = 8'($urandom_range(int'(DATA_MAX) + 1, 255));
        while (t == DATA_ALT || t == TYPE_ACK);
        return t;
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  body[$];
        logic [7:0]  csum;
        logic [7:0]  trl;
        logic [7:0]  b0;
        logic [7:0]  b1;
        int unsigned blen;
        logic [15:0] plen;
        case (kind)
            FK_BAD_HDR: begin
                do begin
                    b0 = ($urandom_range(0, 1)) ? SYNC0 : 8'($urandom_range(0, 255));
                    b1 = 8'($urandom_range(0, 255));
                end while (b0 == SYNC0 && b1 == SYNC1);
                push_byte(b0);
                push_byte(b1);
                push_byte(8'($urandom_range(0, 255)));
                push_byte(8'($urandom_range(0, 255)));
                return;
            end
            FK_OVERFLOW: begin
                blen = $urandom_range(58, 32767);
                push_byte(SYNC0);
                push_byte(SYNC1);
                push_byte({1'($urandom_range(0, 1)), 7'(blen >> 8)});
                push_byte(8'(blen));
                while (sb.fill != 0) push_byte(8'($urandom_range(0, 255)));
                return;
            end
            FK_NOISE: begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                return;
            end
            FK_ACK_OK, FK_ACK_FAIL: blen = $urandom_range(4, 10);
            FK_ACK_SHORT:           blen = $urandom_range(1, 3);
            FK_BAD_CMD:             blen = $urandom_range(2, 20);
            FK_DATA_SHORT:          blen = $urandom_range(1, 12);
            FK_UNKNOWN:             blen = $urandom_range(1, 10);
            FK_EMPTY:               blen = 0;
            default: blen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 57)
                                                        : $urandom_range(13, 24);
        endcase
        for (int i = 0; i < blen; i++) body.push_back(8'($urandom_range(0, 255)));
        case (kind)
            FK_ACK_OK, FK_ACK_FAIL, FK_ACK_SHORT: begin
                body[0] = TYPE_ACK;
                if (blen >= 4) begin
                    body[1] = ACK_CMD;
                    body[3] = ACK_OK;
                end
                if (kind == FK_ACK_FAIL) begin
                    if ($urandom_range(0, 1)) body[1] = body[1] ^ 8'($urandom_range(1, 255));
                    else body[3] = body[3] ^ 8'($urandom_range(1, 255));
                end
            end
            FK_BAD_CMD: begin
                body[0] = data_tag();
                body[1] = DATA_CMD ^ 8'($urandom_range(1, 255));
            end
            FK_DATA_SHORT: begin
                body[0] = data_tag();
                if (blen >= 2) body[1] = DATA_CMD;
            end
            FK_UNKNOWN: body[0] = unknown_tag();
            FK_EMPTY: ;
            default: begin
                body[0] = data_tag();
                body[1] = DATA_CMD;
                case ($urandom_range(0, 3))
                    0:       plen = 16'd0;
                    1:       plen = 16'((blen > PAYLOAD_OFS) ? blen - PAYLOAD_OFS : 0);
                    2:       plen = 16'($urandom_range(0, 65535));
                    default: plen = 16'($urandom_range(0, 12));
                endcase
                body[11] = plen[15:8];
                body[12] = plen[7:0];
            end
        endcase
        csum = 8'h00;
        foreach (body[i]) csum ^= body[i];
        trl = TRAILER;
        if (kind == FK_BAD_SUM) csum = csum ^ 8'($urandom_range(1, 255));
        if (kind == FK_BAD_TRAILER) trl = TRAILER ^ 8'($urandom_range(1, 255));
        push_byte(SYNC0);
        push_byte(SYNC1);
        push_byte({1'($urandom_range(0, 1)), 7'(blen >> 8)});
        push_byte(8'(blen));
        foreach (body[i]) push_byte(body[i]);
        push_byte(csum);
        push_byte(trl);
    endtask

    function automatic frame_kind_t pick_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return FK_DATA;
        if (p < 45) return FK_ACK_OK;
        if (p < 51) return FK_ACK_FAIL;
        if (p < 55) return FK_ACK_SHORT;
        if (p < 60) return FK_BAD_CMD;
        if (p < 65) return FK_DATA_SHORT;
        if (p < 70) return FK_UNKNOWN;
        if (p < 76) return FK_BAD_SUM;
        if (p < 81) return FK_BAD_TRAILER;
        if (p < 86) return FK_BAD_HDR;
        if (p < 89) return FK_EMPTY;
        if (p < 92) return FK_OVERFLOW;
        return FK_NOISE;
    endfunction

    initial begin
        logic [7:0] directed[$];
        bit         held;
        bit         drained;
        int         waited;
        held    = 1'b0;
        drained = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bad header, good ack, empty body with the length top bit set
        directed = {8'h00, 8'hFF, 8'h00, 8'hFF,
                    SYNC0, SYNC1, 8'h00, 8'h04, TYPE_ACK, ACK_CMD, 8'hFF, ACK_OK,
                    TYPE_ACK ^ ACK_CMD ^ 8'hFF ^ ACK_OK, TRAILER,
                    SYNC0, SYNC1, 8'h80, 8'h00, 8'h00, TRAILER};
        foreach (directed[i]) push_byte(directed[i]);

        while (sent_bytes < ITEM_TARGET) begin
            if (!held && sent_bytes > 150) begin
                held     = 1'b1;
                hold_req = 200;
                send_frame(FK_DATA);
            end else if (!drained && sent_bytes > 230) begin
                drained = 1'b1;
                drain_results();
            end
            if (sent_bytes > ITEM_TARGET - 70) quiet = 1'b1;
            send_frame(pick_kind());
            while (sb.fill != 0) push_byte(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.due_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (sb.due_words.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, sb.due_words.size());
        if (sb.errors == 0 && sb.due_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
